[src/auto_contrast_grey_mapper_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the auto contrast grey mapper
// Shared property wrappers, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef AUTO_CONTRAST_GREY_MAPPER_MACROS_SVH
`define AUTO_CONTRAST_GREY_MAPPER_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression holds at every edge out of reset
`define ACG_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ACG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ACG_ASSERT_ALWAYS(label, expr, msg)
`define ACG_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[src/acg_pkg.sv]
// ----------------------------------------------------------------------------
// acg_pkg
// Types, codes and the gain table of the auto contrast grey mapper.
// ----------------------------------------------------------------------------
package acg_pkg;

  typedef enum logic {
    OP_MEASURE = 1'b0,
    OP_MAP     = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] pixel;
    logic       frame_start;
  } acg_item_t;

  typedef struct packed {
    logic       auto_contrast;
    logic [7:0] manual_offset;
    logic [7:0] manual_gain;
  } acg_cfg_t;

  // 255 / span, rounded down; a flat frame (span of zero) maps with gain 1
  function automatic logic [7:0] gain_lookup(input logic [7:0] span);
    logic [7:0] g;
    case (span) inside
      8'd0:           g = 8'd1;
      8'd1:           g = 8'd255;
      8'd2:           g = 8'd127;
      8'd3:           g = 8'd85;
      8'd4:           g = 8'd63;
      8'd5:           g = 8'd51;
      8'd6:           g = 8'd42;
      8'd7:           g = 8'd36;
      8'd8:           g = 8'd31;
      8'd9:           g = 8'd28;
      8'd10:          g = 8'd25;
      8'd11:          g = 8'd23;
      8'd12:          g = 8'd21;
      8'd13:          g = 8'd19;
      8'd14:          g = 8'd18;
      8'd15:          g = 8'd17;
      [8'd16:8'd17]:  g = 8'd15;
      8'd18:          g = 8'd14;
      8'd19:          g = 8'd13;
      [8'd20:8'd21]:  g = 8'd12;
      [8'd22:8'd23]:  g = 8'd11;
      [8'd24:8'd25]:  g = 8'd10;
      [8'd26:8'd28]:  g = 8'd9;
      [8'd29:8'd31]:  g = 8'd8;
      [8'd32:8'd36]:  g = 8'd7;
      [8'd37:8'd42]:  g = 8'd6;
      [8'd43:8'd51]:  g = 8'd5;
      [8'd52:8'd63]:  g = 8'd4;
      [8'd64:8'd85]:  g = 8'd3;
      [8'd86:8'd127]: g = 8'd2;
      default:        g = 8'd1;
    endcase
    return g;
  endfunction

endpackage

[src/acg_front.sv]
// ----------------------------------------------------------------------------
// acg_front
// Input register: takes beats from the stream, decodes the opcode and
// hands classified items to the queue.
// ----------------------------------------------------------------------------
module acg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [7:0]          in_pixel,
  input  logic                in_frame_start,
  output logic                push_valid,
  input  logic                push_ready,
  output acg_pkg::acg_item_t  push_item
);
  import acg_pkg::*;

  logic      held;
  acg_item_t item;
  acg_item_t item_next;

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  always_comb begin
    item_next.op          = in_opcode ? OP_MAP : OP_MEASURE;
    item_next.pixel       = in_pixel;
    // frame start only means something on a measure beat
    item_next.frame_start = in_frame_start && !in_opcode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

[src/acg_queue.sv]
// ----------------------------------------------------------------------------
// acg_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module acg_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  acg_pkg::acg_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output acg_pkg::acg_item_t  out_item
);
  import acg_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  acg_item_t       slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

[src/acg_back.sv]
// ----------------------------------------------------------------------------
// acg_back
// Executes queued items: measure beats update the frame extremes, map beats
// run offset, gain lookup and multiply into the output register.
// ----------------------------------------------------------------------------
`include "auto_contrast_grey_mapper_macros.svh"

module acg_back (
  input  logic                clk,
  input  logic                rst,
  input  acg_pkg::acg_cfg_t   cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  acg_pkg::acg_item_t  q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_grey
);
  import acg_pkg::*;

  logic [7:0]  lowest_level;
  logic [7:0]  highest_level;
  logic        a_valid;
  logic [7:0]  a_sum;
  logic [7:0]  a_gain;
  logic        o_valid;
  logic [7:0]  o_data;

  logic        out_can;
  logic        a_free;
  logic        pop;
  logic        pop_map;
  logic        pop_meas;
  logic [8:0]  off_wide;
  logic [7:0]  offset;
  logic [7:0]  span;
  logic [7:0]  gain;
  logic [8:0]  sum_wide;
  logic [15:0] product;

  assign out_can  = !o_valid || out_ready;
  assign a_free   = !a_valid || out_can;
  // measure beats never wait on the map pipeline
  assign q_ready  = (q_item.op == OP_MEASURE) || a_free;
  assign pop      = q_valid && q_ready;
  assign pop_map  = pop && (q_item.op == OP_MAP);
  assign pop_meas = pop && (q_item.op == OP_MEASURE);

  always_comb begin
    off_wide = 9'd256 - {1'b0, lowest_level};
    span     = (highest_level >= lowest_level) ? highest_level - lowest_level : 8'd0;
    if (cfg.auto_contrast) begin
      offset = off_wide[7:0];
      gain   = gain_lookup(span);
    end else begin
      offset = cfg.manual_offset;
      gain   = cfg.manual_gain;
    end
    sum_wide = {1'b0, q_item.pixel} + {1'b0, offset};
    product  = {8'd0, a_sum} * {8'd0, a_gain};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_level  <= 8'd0;
      highest_level <= 8'd0;
      a_valid       <= 1'b0;
      o_valid       <= 1'b0;
    end else begin
      if (pop_meas) begin
        if (q_item.frame_start) begin
          lowest_level  <= q_item.pixel;
          highest_level <= q_item.pixel;
        end else begin
          if (q_item.pixel > highest_level) highest_level <= q_item.pixel;
          if (q_item.pixel < lowest_level)  lowest_level  <= q_item.pixel;
        end
      end
      if (a_free) begin
        a_valid <= pop_map;
      end
      if (out_can) begin
        o_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_map) begin
      a_sum  <= sum_wide[7:0];
      a_gain <= gain;
    end
    if (a_valid && out_can) begin
      o_data <= product[7:0];
    end
  end

  assign out_valid = o_valid;
  assign out_grey  = o_data;

  `ACG_ASSERT_ALWAYS(a_extremes_ordered, lowest_level <= highest_level, "extremes out of order")
  `ACG_ASSERT_NEXT(a_frame_restart, pop_meas && q_item.frame_start, lowest_level == highest_level, "frame start did not restart extremes")
  `ACG_ASSERT_NEXT(a_measure_no_result, pop_meas && !a_valid, !a_valid, "measure beat entered the map pipeline")

endmodule

[src/auto_contrast_grey_mapper.sv]
// ----------------------------------------------------------------------------
// auto_contrast_grey_mapper
// Min/max contrast stretch of 8-bit grey pixels with an APB register port.
// ----------------------------------------------------------------------------
// Each frame is streamed twice: measure beats (tuser[0] = 0) track the
// lowest and highest level, restarting on tuser[1]; map beats (tuser[0] = 1)
// return one byte, ((pixel + offset) * gain) mod 256. Offset and gain come
// from the registers, or with auto contrast on from the extremes as they
// stand when the map beat is executed, the gain read from a 256-entry table
// of 255 / span. Both kinds of beat sustain one per clock while the output
// is not stalled; a map beat's result passes the input register, the queue,
// the offset/gain stage and the multiply into the output register. The
// QUEUE_DEPTH-entry queue between front and back absorbs output stalls.
// Write registers only while no beat is in flight.
module auto_contrast_grey_mapper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  input  logic [1:0]  s_tuser,   // [0] opcode, [1] frame_start
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] grey_out
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import acg_pkg::*;

  localparam logic [1:0] REG_AUTO_CONTRAST = 2'd0;
  localparam logic [1:0] REG_MANUAL_OFFSET = 2'd1;
  localparam logic [1:0] REG_MANUAL_GAIN   = 2'd2;

  acg_cfg_t   cfg;
  logic       wr_en;
  logic       push_valid;
  logic       push_ready;
  acg_item_t  push_item;
  logic       pop_valid;
  logic       pop_ready;
  acg_item_t  pop_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_contrast <= 1'b0;
      cfg.manual_offset <= 8'd0;
      cfg.manual_gain   <= 8'd1;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_AUTO_CONTRAST: cfg.auto_contrast <= pwdata[0];
        REG_MANUAL_OFFSET: cfg.manual_offset <= pwdata[7:0];
        REG_MANUAL_GAIN:   cfg.manual_gain   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_AUTO_CONTRAST: prdata = {31'd0, cfg.auto_contrast};
      REG_MANUAL_OFFSET: prdata = {24'd0, cfg.manual_offset};
      REG_MANUAL_GAIN:   prdata = {24'd0, cfg.manual_gain};
      default:           prdata = 32'd0;
    endcase
  end

  acg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_opcode      (s_tuser[0]),
    .in_pixel       (s_tdata),
    .in_frame_start (s_tuser[1]),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  acg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_item   (push_item),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_item  (pop_item)
  );

  acg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_item    (pop_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_grey  (m_tdata)
  );

endmodule
